>>> hdl/frc_pkg.sv
// Shared types and constants of the framed packet receiver.
// No dependencies; every other file of the block but frc_if imports this package.
package frc_pkg;

  // Configuration register map: index = paddr[3:2].
  localparam int unsigned ADDR_W = 4;
  typedef logic [1:0] frc_reg_idx_t;
  localparam frc_reg_idx_t REG_MARKER_FIRST  = 2'd0;
  localparam frc_reg_idx_t REG_MARKER_SECOND = 2'd1;
  localparam frc_reg_idx_t REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [7:0]  MARKER_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  MARKER_SECOND_RST = 8'h55;
  localparam logic [15:0] TIMEOUT_RST       = 16'd100;

  // CRC-16/MODBUS, reflected form.
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Frame parser phases.
  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_MARK2 = 8'b0000_0010,
    PH_FUNC  = 8'b0000_0100,
    PH_LENHI = 8'b0000_1000,
    PH_LENLO = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CRCHI = 8'b0100_0000,
    PH_CRCLO = 8'b1000_0000
  } frc_phase_e;

  // Result sequencer states.
  typedef enum logic [3:0] {
    CT_IDLE   = 4'b0001,
    CT_PUSH   = 4'b0010,
    CT_RUN_RD = 4'b0100,
    CT_RUN_WR = 4'b1000
  } frc_ctl_e;

  // Control of the bit-serial CRC unit.
  typedef struct packed {
    logic start;
    logic seed_init;
  } frc_crc_ctl_t;

  // One result word.
  typedef struct packed {
    logic       frame_ok;
    logic       payload_present;
    logic [7:0] payload_byte;
    logic [4:0] payload_index;
    logic [5:0] payload_length;
    logic [7:0] function_code;
    logic       last_of_run;
    logic       bad_length_flag;
    logic       bad_crc_flag;
    logic       hunting;
  } frc_res_t;

endpackage

>>> hdl/frc_if.sv
// Valid/ready channel interfaces of the framed packet receiver.
// No dependencies.
interface frc_rx_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink   (input valid, operation, rx_byte, output ready);
endinterface

interface frc_res_if;
  logic       valid;
  logic       ready;
  logic       frame_ok;
  logic       payload_present;
  logic [7:0] payload_byte;
  logic [4:0] payload_index;
  logic [5:0] payload_length;
  logic [7:0] function_code;
  logic       last_of_run;
  logic       bad_length_flag;
  logic       bad_crc_flag;
  logic       hunting;

  modport source (output valid, frame_ok, payload_present, payload_byte, payload_index,
                  payload_length, function_code, last_of_run, bad_length_flag,
                  bad_crc_flag, hunting, input ready);
  modport sink   (input valid, frame_ok, payload_present, payload_byte, payload_index,
                  payload_length, function_code, last_of_run, bad_length_flag,
                  bad_crc_flag, hunting, output ready);
endinterface

>>> hdl/frc_crc_serial.sv
// Bit-serial CRC-16/MODBUS unit: folds one byte at a time into the running CRC.
// Depends on frc_pkg.
module frc_crc_serial import frc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  frc_crc_ctl_t ctl_i,
  input  logic [7:0]   byte_i,
  output logic         busy_o,
  output logic [15:0]  crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] seed;
  logic [15:0] step_in;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  assign seed    = ctl_i.seed_init ? CRC_INIT : crc_q;
  assign step_in = ctl_i.start ? (seed ^ {8'h00, byte_i}) : crc_q;

  // The start cycle already does the first of the eight shift steps.
  always_comb begin
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctl_i.start || busy_q) begin
      crc_d = step_in[0] ? ((step_in >> 1) ^ CRC_POLY) : (step_in >> 1);
    end
    if (ctl_i.start) begin
      cnt_d  = 3'd1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign crc_o  = crc_q;

endmodule

>>> hdl/framed_packet_receiver_crc16.sv
// Channel   Dir  Handshake      Word
// rx_i      in   valid/ready    operation, rx_byte
// res_o     out  valid/ready    frame_ok .. hunting (one status or payload word)
// apb       in   psel/penable   marker_first, marker_second, timeout_ticks
//
// A received byte that feeds the CRC occupies the input for its accept plus seven
// more steps of the bit-serial CRC unit; every item also holds the input until the
// result sequencer is idle again. A good frame emits its payload word by word, each
// word fetched by the registered read of the payload memory. Reset is asynchronous
// and active low; the payload memory is not cleared. A stalled output holds its
// word in the output register while the next item is already being parsed.
//
// Top level of the framed packet receiver; depends on frc_pkg, frc_if and frc_crc_serial.
module framed_packet_receiver_crc16 import frc_pkg::*; #(
  parameter int unsigned MAX_DATA = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  frc_rx_if.sink            rx_i,
  frc_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CNT_W = $clog2(MAX_DATA + 1);
  localparam int unsigned IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  // Configuration registers.
  logic [7:0]   marker_first_q;
  logic [7:0]   marker_second_q;
  logic [15:0]  timeout_q;
  logic         cfg_we;
  frc_reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_first_q  <= MARKER_FIRST_RST;
      marker_second_q <= MARKER_SECOND_RST;
      timeout_q       <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MARKER_FIRST:  marker_first_q  <= pwdata[7:0];
        REG_MARKER_SECOND: marker_second_q <= pwdata[7:0];
        REG_TIMEOUT_TICKS: timeout_q       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MARKER_FIRST:  prdata = {24'h0, marker_first_q};
      REG_MARKER_SECOND: prdata = {24'h0, marker_second_q};
      REG_TIMEOUT_TICKS: prdata = {16'h0, timeout_q};
      default:           prdata = '0;
    endcase
  end

  // Parser state.
  frc_phase_e        phase_q, phase_d;
  frc_ctl_e          ctl_q, ctl_d;
  logic [7:0]        func_q, func_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  count_inc;
  logic [7:0]        crc_hi_q, crc_hi_d;
  logic              len_err_q, len_err_d;
  logic              crc_err_q, crc_err_d;
  logic [15:0]       idle_q, idle_d;
  logic              pend_ok_q, pend_ok_d;
  logic [IDX_W-1:0]  run_idx_q, run_idx_d;
  logic              run_last;

  logic              rx_acc;
  logic              good;
  logic              mem_we;
  logic [15:0]       len_full;
  frc_crc_ctl_t      crc_ctl;
  logic              crc_busy;
  logic [15:0]       crc_val;

  // Output register.
  frc_res_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              out_load;

  // Payload memory.
  logic [7:0]        mem [MAX_DATA];
  logic [7:0]        rd_q;

  frc_crc_serial u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .byte_i (rx_i.rx_byte),
    .busy_o (crc_busy),
    .crc_o  (crc_val)
  );

  assign rx_i.ready = (ctl_q == CT_IDLE) && !crc_busy;
  assign rx_acc     = rx_i.valid && rx_i.ready;
  assign len_full   = {len_hi_q, rx_i.rx_byte};
  assign count_inc  = count_q + CNT_W'(1);
  assign run_last   = (CNT_W'(run_idx_q) + CNT_W'(1)) == len_q;
  assign out_free   = !out_valid_q || res_o.ready;

  // Frame parser: updates the state on each accepted word.
  always_comb begin
    phase_d   = phase_q;
    func_d    = func_q;
    len_hi_d  = len_hi_q;
    len_d     = len_q;
    count_d   = count_q;
    crc_hi_d  = crc_hi_q;
    len_err_d = len_err_q;
    crc_err_d = crc_err_q;
    idle_d    = idle_q;
    good      = 1'b0;
    mem_we    = 1'b0;
    crc_ctl   = '0;
    if (rx_acc) begin
      if (rx_i.operation == OP_TICK) begin
        if (idle_q != TICK_MAX) begin
          idle_d = idle_q + 16'd1;
        end
        if (phase_q != PH_HUNT && idle_d >= timeout_q) begin
          phase_d  = PH_HUNT;
          func_d   = '0;
          len_hi_d = '0;
          len_d    = '0;
          count_d  = '0;
          crc_hi_d = '0;
        end
      end else begin
        idle_d = '0;
        case (phase_q)
          PH_HUNT: begin
            if (rx_i.rx_byte == marker_first_q) begin
              len_err_d = 1'b0;
              crc_err_d = 1'b0;
              phase_d   = PH_MARK2;
            end
          end
          PH_MARK2: begin
            if (rx_i.rx_byte == marker_second_q) begin
              phase_d = PH_FUNC;
            end else if (rx_i.rx_byte != marker_first_q) begin
              phase_d = PH_HUNT;
            end
          end
          PH_FUNC: begin
            func_d            = rx_i.rx_byte;
            crc_ctl.start     = 1'b1;
            crc_ctl.seed_init = 1'b1;
            phase_d           = PH_LENHI;
          end
          PH_LENHI: begin
            len_hi_d      = rx_i.rx_byte;
            crc_ctl.start = 1'b1;
            phase_d       = PH_LENLO;
          end
          PH_LENLO: begin
            crc_ctl.start = 1'b1;
            count_d       = '0;
            if (len_full > 16'(MAX_DATA)) begin
              len_err_d = 1'b1;
              phase_d   = PH_HUNT;
              func_d    = '0;
              len_hi_d  = '0;
              len_d     = '0;
              crc_hi_d  = '0;
            end else begin
              len_d   = CNT_W'(len_full);
              phase_d = (len_full == 16'd0) ? PH_CRCHI : PH_DATA;
            end
          end
          PH_DATA: begin
            mem_we        = 1'b1;
            crc_ctl.start = 1'b1;
            count_d       = count_inc;
            if (count_inc >= len_q) begin
              phase_d = PH_CRCHI;
            end
          end
          PH_CRCHI: begin
            crc_hi_d = rx_i.rx_byte;
            phase_d  = PH_CRCLO;
          end
          PH_CRCLO: begin
            phase_d = PH_HUNT;
            if ({crc_hi_q, rx_i.rx_byte} == crc_val) begin
              good = 1'b1;
            end else begin
              crc_err_d = 1'b1;
            end
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  // Result sequencer: one status word, or a run of payload words for a good frame with a payload.
  always_comb begin
    ctl_d     = ctl_q;
    pend_ok_d = pend_ok_q;
    run_idx_d = run_idx_q;
    out_load  = 1'b0;
    out_d     = out_q;
    case (ctl_q)
      CT_IDLE: begin
        if (rx_acc) begin
          run_idx_d = '0;
          pend_ok_d = good;
          ctl_d     = (good && len_q != '0) ? CT_RUN_RD : CT_PUSH;
        end
      end
      CT_PUSH: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_d                 = '0;
          out_d.frame_ok        = pend_ok_q;
          out_d.function_code   = pend_ok_q ? func_q : 8'h00;
          out_d.last_of_run     = 1'b1;
          out_d.bad_length_flag = len_err_q;
          out_d.bad_crc_flag    = crc_err_q;
          out_d.hunting         = (phase_q == PH_HUNT);
          ctl_d                 = CT_IDLE;
        end
      end
      CT_RUN_RD: begin
        // Memory data for run_idx_q is registered at this edge.
        ctl_d = CT_RUN_WR;
      end
      CT_RUN_WR: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_d.frame_ok        = 1'b1;
          out_d.payload_present = 1'b1;
          out_d.payload_byte    = rd_q;
          out_d.payload_index   = 5'(run_idx_q);
          out_d.payload_length  = 6'(len_q);
          out_d.function_code   = func_q;
          out_d.last_of_run     = run_last;
          out_d.bad_length_flag = len_err_q;
          out_d.bad_crc_flag    = crc_err_q;
          out_d.hunting         = (phase_q == PH_HUNT);
          if (run_last) begin
            ctl_d = CT_IDLE;
          end else begin
            run_idx_d = run_idx_q + IDX_W'(1);
            ctl_d     = CT_RUN_RD;
          end
        end
      end
      default: begin
        ctl_d = CT_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      ctl_q       <= CT_IDLE;
      func_q      <= '0;
      len_hi_q    <= '0;
      len_q       <= '0;
      count_q     <= '0;
      crc_hi_q    <= '0;
      len_err_q   <= 1'b0;
      crc_err_q   <= 1'b0;
      idle_q      <= '0;
      pend_ok_q   <= 1'b0;
      run_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      ctl_q       <= ctl_d;
      func_q      <= func_d;
      len_hi_q    <= len_hi_d;
      len_q       <= len_d;
      count_q     <= count_d;
      crc_hi_q    <= crc_hi_d;
      len_err_q   <= len_err_d;
      crc_err_q   <= crc_err_d;
      idle_q      <= idle_d;
      pend_ok_q   <= pend_ok_d;
      run_idx_q   <= run_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IDX_W-1:0]] <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[run_idx_q];
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.frame_ok        = out_q.frame_ok;
  assign res_o.payload_present = out_q.payload_present;
  assign res_o.payload_byte    = out_q.payload_byte;
  assign res_o.payload_index   = out_q.payload_index;
  assign res_o.payload_length  = out_q.payload_length;
  assign res_o.function_code   = out_q.function_code;
  assign res_o.last_of_run     = out_q.last_of_run;
  assign res_o.bad_length_flag = out_q.bad_length_flag;
  assign res_o.bad_crc_flag    = out_q.bad_crc_flag;
  assign res_o.hunting         = out_q.hunting;

`ifndef SYNTH
  // Every accepted word keeps the input closed for at least the next cycle.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_acc |=> !rx_i.ready)
    else $error("input accepted again right after an accepted word");

  // Bytes covered by the CRC must start the serial CRC unit.
  a_crc_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_acc && rx_i.operation == OP_BYTE &&
     (phase_q == PH_FUNC || phase_q == PH_LENHI || phase_q == PH_LENLO ||
      phase_q == PH_DATA)) |=> crc_busy)
    else $error("CRC unit idle after a covered byte");

  // Payload writes stay within the declared length.
  a_mem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (count_q < len_q))
    else $error("payload write beyond declared length");
`endif

endmodule
